// ===== src/spsq_pkg.sv =====
// Shared types, codes and coil tables for the stepper phase sequencer.
// Used by the channel interfaces, the divide/multiply unit and the top level.
package spsq_pkg;

   localparam int CfgWidth    = 16;
   localparam int DistWidth   = 16;
   localparam int SpeedWidth  = 16;
   localparam int TargetWidth = 32;
   localparam int PhaseWidth  = 4;
   localparam int CoilWidth   = 4;
   localparam int Phases      = 8;

   localparam logic [PhaseWidth-1:0] PHASE_LAST = PhaseWidth'(Phases);

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_FWD  = 2'd1,
      CMD_BWD  = 2'd2,
      CMD_INIT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_BUSY = 2'd1,
      ST_WAIT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      MODE_INIT     = 3'd0,
      MODE_FWD      = 3'd1,
      MODE_FWD_DONE = 3'd2,
      MODE_BWD      = 3'd3,
      MODE_BWD_DONE = 3'd4
   } mode_type;

   typedef enum logic [0:0] {
      CSR_REV_LENGTH    = 1'd0,
      CSR_STEPS_PER_REV = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_CALC
   } top_state_type;

   typedef enum logic [1:0] {
      DM_IDLE,
      DM_DIV,
      DM_MUL,
      DM_DONE
   } dm_state_type;

   typedef struct packed {
      logic                 start;
      logic [DistWidth-1:0] dividend;
      logic [CfgWidth-1:0]  divisor;
      logic [CfgWidth-1:0]  multiplier;
   } dm_req_type;

   typedef struct packed {
      logic                   done;
      logic [TargetWidth-1:0] product;
   } dm_rsp_type;

   function automatic logic [CoilWidth-1:0] fwd_coils(input logic [2:0] idx);
      logic [CoilWidth-1:0] c;
      case (idx)
         3'd0:    c = 4'h5;
         3'd1:    c = 4'hD;
         3'd2:    c = 4'h9;
         3'd3:    c = 4'hB;
         3'd4:    c = 4'hA;
         3'd5:    c = 4'hE;
         3'd6:    c = 4'h6;
         default: c = 4'h7;
      endcase
      return c;
   endfunction

   // Reverse order walks the forward table from the far end.
   function automatic logic [CoilWidth-1:0] bwd_coils(input logic [2:0] idx);
      return fwd_coils(3'd7 - idx);
   endfunction

endpackage

// ===== src/spsq_req_if.sv =====
// Command channel of the stepper phase sequencer: valid/ready plus payload.
// Depends on spsq_pkg for field widths.
interface spsq_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [spsq_pkg::DistWidth-1:0]  distance;
   logic [spsq_pkg::SpeedWidth-1:0] speed;

   modport source (output valid, cmd, distance, speed, input ready);
   modport sink   (input valid, cmd, distance, speed, output ready);
endinterface

// ===== src/spsq_rsp_if.sv =====
// Result channel of the stepper phase sequencer: valid/ready plus payload.
// Depends on spsq_pkg for field widths.
interface spsq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [spsq_pkg::CoilWidth-1:0] coil_pattern;
   logic                           drive_enable;
   logic [2:0]                     motion_state;

   modport source (output valid, status, coil_pattern, drive_enable, motion_state,
                   input ready);
   modport sink   (input valid, status, coil_pattern, drive_enable, motion_state,
                   output ready);
endinterface

// ===== src/stepper_phase_sequencer_top.sv =====
// Stepper phase sequencer top level: command decode, motion state, output register.
// Depends on spsq_pkg, spsq_req_if, spsq_rsp_if and spsq_divmul.
// Timing: tick, init and refused moves show rsp valid in the cycle after acceptance; accepted moves
// run a restoring divide and a registered multiply in spsq_divmul, then commit when out_free.
// Throughput: one command at a time; the next is taken once the previous result is
// in the output register and that register is free or being drained.
// Reset: synchronous, clears motion state, counters and coils; rev_length=1, steps_per_rev=8.
module stepper_phase_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   spsq_req_if.sink                          req_chan,
   spsq_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [spsq_pkg::CfgWidth-1:0]     csr_wdata
);
   import spsq_pkg::*;

   top_state_type          state_ff, state_in;
   logic [CfgWidth-1:0]    rev_ff, spr_ff;
   mode_type               mode_ff, mode_in;
   logic [PhaseWidth-1:0]  phase_ff, phase_in;
   logic [TargetWidth-1:0] count_ff, count_in;
   logic [TargetWidth-1:0] target_ff, target_in;
   logic [SpeedWidth-1:0]  delay_ff, delay_in;
   logic [SpeedWidth-1:0]  period_ff, period_in;
   logic [CoilWidth-1:0]   coil_ff, coil_in;
   logic                   enable_ff, enable_in;

   logic                   hold_fwd_ff, hold_fwd_in;
   logic [SpeedWidth-1:0]  hold_speed_ff, hold_speed_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             out_status_ff, out_status_in;

   dm_req_type             dm_req;
   dm_rsp_type             dm_rsp;

   logic                   out_free;
   logic                   accept;
   cmd_type                cmd;
   logic [SpeedWidth-1:0]  delay_dec;
   logic [PhaseWidth-1:0]  phase_wrap;
   logic [PhaseWidth-1:0]  phase_next;
   mode_type               mode_tick;

   spsq_divmul u_divmul (
      .clock  (clock),
      .reset  (reset),
      .dm_req (dm_req),
      .dm_rsp (dm_rsp)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == TOP_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign cmd            = cmd_type'(req_chan.cmd);

   assign delay_dec  = delay_ff - 1'b1;
   assign phase_wrap = (phase_ff == PHASE_LAST) ? '0 : phase_ff;
   assign phase_next = phase_wrap + 1'b1;

   always_comb begin
      mode_tick = mode_ff;
      if (count_ff == target_ff) begin
         mode_tick = (mode_ff == MODE_FWD) ? MODE_FWD_DONE : MODE_BWD_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rev_ff       <= CfgWidth'(1);
         spr_ff       <= CfgWidth'(8);
         mode_ff      <= MODE_INIT;
         phase_ff     <= '0;
         count_ff     <= '0;
         target_ff    <= '0;
         delay_ff     <= '0;
         period_ff    <= '0;
         coil_ff      <= '0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
         delay_ff     <= delay_in;
         period_ff    <= period_in;
         coil_ff      <= coil_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_REV_LENGTH:    rev_ff <= csr_wdata;
               CSR_STEPS_PER_REV: spr_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      hold_fwd_ff   <= hold_fwd_in;
      hold_speed_ff <= hold_speed_in;
      out_status_ff <= out_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      target_in     = target_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      coil_in       = coil_ff;
      enable_in     = enable_ff;
      hold_fwd_in   = hold_fwd_ff;
      hold_speed_in = hold_speed_ff;
      out_status_in = out_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      dm_req.start      = 1'b0;
      dm_req.dividend   = req_chan.distance;
      dm_req.divisor    = rev_ff;
      dm_req.multiplier = spr_ff;

      unique case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_FWD, CMD_BWD: begin
                     if ((cmd == CMD_FWD && mode_ff == MODE_FWD) ||
                         (cmd == CMD_BWD && mode_ff == MODE_BWD)) begin
                        out_status_in = ST_BUSY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        dm_req.start  = 1'b1;
                        hold_fwd_in   = (cmd == CMD_FWD);
                        hold_speed_in = req_chan.speed;
                        state_in      = TOP_CALC;
                     end
                  end
                  CMD_INIT: begin
                     phase_in      = '0;
                     mode_in       = MODE_INIT;
                     count_in      = '0;
                     period_in     = '0;
                     delay_in      = '0;
                     out_status_in = ST_DONE;
                     rsp_valid_in  = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     if (delay_ff != '0 && delay_dec != '0) begin
                        // still counting down the step delay
                        delay_in      = delay_dec;
                        out_status_in = ST_WAIT;
                     end else begin
                        delay_in  = '0;
                        phase_in  = phase_wrap;
                        mode_in   = mode_tick;
                        count_in  = count_ff + 1'b1;
                        out_status_in = ST_BUSY;
                        if (mode_tick == MODE_FWD_DONE || mode_tick == MODE_BWD_DONE) begin
                           coil_in       = '0;
                           out_status_in = ST_DONE;
                        end else if (mode_tick == MODE_FWD || mode_tick == MODE_BWD) begin
                           phase_in = phase_next;
                           coil_in  = (mode_tick == MODE_FWD) ?
                                      fwd_coils(phase_wrap[2:0]) :
                                      bwd_coils(phase_wrap[2:0]);
                           delay_in = period_ff;
                        end
                     end
                  end
               endcase
            end
         end
         TOP_CALC: begin
            // commit the move once the target is ready and the output slot is free
            if (dm_rsp.done && out_free) begin
               period_in     = hold_speed_ff;
               phase_in      = '0;
               target_in     = dm_rsp.product;
               mode_in       = hold_fwd_ff ? MODE_FWD : MODE_BWD;
               count_in      = '0;
               enable_in     = 1'b1;
               out_status_in = ST_DONE;
               rsp_valid_in  = 1'b1;
               state_in      = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   // Coil, enable and mode registers already reflect the state after the item.
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.coil_pattern = coil_ff;
   assign rsp_chan.drive_enable = enable_ff;
   assign rsp_chan.motion_state = mode_ff;

endmodule

// ===== src/spsq_divmul.sv =====
// Iterative target unit: restoring divide one quotient bit per cycle,
// then one registered multiply. Depends on spsq_pkg.
module spsq_divmul (
   input  logic                 clock,
   input  logic                 reset,
   input  spsq_pkg::dm_req_type dm_req,
   output spsq_pkg::dm_rsp_type dm_rsp
);
   import spsq_pkg::*;

   localparam int CntWidth = $clog2(DistWidth);
   localparam logic [CntWidth-1:0] CNT_LAST = CntWidth'(DistWidth - 1);

   dm_state_type           state_ff, state_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic [CfgWidth-1:0]    rem_ff, rem_in;
   logic [DistWidth-1:0]   quo_ff, quo_in;
   logic [CfgWidth-1:0]    dvsr_ff, dvsr_in;
   logic [CfgWidth-1:0]    mult_ff, mult_in;
   logic [TargetWidth-1:0] prod_ff, prod_in;

   logic [CfgWidth:0]   shifted;
   logic [CfgWidth+1:0] diff;
   logic                borrow;

   // Shared subtractor: trial subtract of the divisor from the shifted remainder.
   // A zero divisor never borrows, so the quotient saturates to all ones.
   assign shifted = {rem_ff, quo_ff[DistWidth-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvsr_ff};
   assign borrow  = diff[CfgWidth+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DM_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
      mult_ff <= mult_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvsr_in  = dvsr_ff;
      mult_in  = mult_ff;
      prod_in  = prod_ff;
      if (dm_req.start) begin
         state_in = DM_DIV;
         cnt_in   = '0;
         rem_in   = '0;
         quo_in   = dm_req.dividend;
         dvsr_in  = dm_req.divisor;
         mult_in  = dm_req.multiplier;
      end else begin
         unique case (state_ff)
            DM_IDLE: ;
            DM_DIV: begin
               rem_in = borrow ? shifted[CfgWidth-1:0] : diff[CfgWidth-1:0];
               quo_in = {quo_ff[DistWidth-2:0], ~borrow};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_in = DM_MUL;
               end
            end
            DM_MUL: begin
               prod_in  = TargetWidth'(quo_ff) * TargetWidth'(mult_ff);
               state_in = DM_DONE;
            end
            DM_DONE: ;
            default: state_in = DM_IDLE;
         endcase
      end
   end

   assign dm_rsp.done    = (state_ff == DM_DONE);
   assign dm_rsp.product = prod_ff;

endmodule

// ===== sim/spsq_motion_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the stepper phase sequencer: watches the command, result and register
// ports, predicts every result and compares it. Depends on spsq_pkg and the channel interfaces.
module spsq_motion_checker (
   input  logic                          clock,
   input  logic                          reset,
   spsq_req_if                           req_mon,
   spsq_rsp_if                           rsp_mon,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [spsq_pkg::CfgWidth-1:0] csr_wdata,
   output int                            fail_count,
   output int                            results_due
);
   import spsq_pkg::*;

   typedef struct packed {
      status_type           status;
      logic [CoilWidth-1:0] coils;
      logic                 enable;
      mode_type             mode;
   } motion_result_type;

   // Forward coil order; reverse order reads it from the far end.
   localparam logic [CoilWidth-1:0] FWD_COILS [Phases] =
      '{4'h5, 4'hD, 4'h9, 4'hB, 4'hA, 4'hE, 4'h6, 4'h7};

   logic [CfgWidth-1:0]    rev_len;
   logic [CfgWidth-1:0]    steps_rev;
   mode_type               mode;
   logic [PhaseWidth-1:0]  phase;
   logic [TargetWidth-1:0] step_cnt;
   logic [TargetWidth-1:0] step_goal;
   logic [SpeedWidth-1:0]  delay_cnt;
   logic [SpeedWidth-1:0]  period;
   logic [CoilWidth-1:0]   coils;
   logic                   enable;

   motion_result_type      pending_results [$];
   motion_result_type      want;
   motion_result_type      got;
   int                     mismatches = 0;

   assign fail_count = mismatches;

   function automatic status_type motion_tick();
      if (delay_cnt != '0) begin
         delay_cnt = delay_cnt - 1'b1;
         if (delay_cnt != '0) return ST_WAIT;
      end
      if (phase == PhaseWidth'(Phases)) phase = '0;
      if (step_cnt == step_goal)
         mode = (mode == MODE_FWD) ? MODE_FWD_DONE : MODE_BWD_DONE;
      step_cnt = step_cnt + 1'b1;
      if (mode == MODE_FWD_DONE || mode == MODE_BWD_DONE) begin
         coils = '0;
         return ST_DONE;
      end
      if (mode == MODE_FWD || mode == MODE_BWD) begin
         phase = phase + 1'b1;
         if (phase >= 1 && phase <= PhaseWidth'(Phases)) begin
            coils     = (mode == MODE_FWD) ? FWD_COILS[phase - 1]
                                           : FWD_COILS[Phases - phase];
            delay_cnt = period;
         end
      end
      return ST_BUSY;
   endfunction

   function automatic motion_result_type advance_motion(cmd_type cmd,
                                                        logic [DistWidth-1:0] travel,
                                                        logic [SpeedWidth-1:0] spd);
      motion_result_type r;
      logic [DistWidth-1:0] revs;
      r.status = ST_DONE;
      case (cmd)
         CMD_FWD, CMD_BWD: begin
            // refuse a move in the direction that already runs
            if ((cmd == CMD_FWD && mode == MODE_FWD) ||
                (cmd == CMD_BWD && mode == MODE_BWD)) begin
               r.status = ST_BUSY;
            end else begin
               revs      = (rev_len == '0) ? 16'hFFFF : travel / rev_len;
               step_goal = TargetWidth'(revs) * TargetWidth'(steps_rev);
               period    = spd;
               phase     = '0;
               step_cnt  = '0;
               enable    = 1'b1;
               mode      = (cmd == CMD_FWD) ? MODE_FWD : MODE_BWD;
            end
         end
         CMD_INIT: begin
            phase     = '0;
            mode      = MODE_INIT;
            step_cnt  = '0;
            period    = '0;
            delay_cnt = '0;
         end
         default: r.status = motion_tick();
      endcase
      r.coils  = coils;
      r.enable = enable;
      r.mode   = mode;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rev_len   = 16'd1;
         steps_rev = 16'd8;
         mode      = MODE_INIT;
         phase     = '0;
         step_cnt  = '0;
         step_goal = '0;
         delay_cnt = '0;
         period    = '0;
         coils     = '0;
         enable    = 1'b0;
         pending_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_REV_LENGTH) rev_len = csr_wdata;
            else steps_rev = csr_wdata;
         end
         // drain before predict: a result never belongs to the item taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{status_type'(rsp_mon.status), rsp_mon.coil_pattern, rsp_mon.drive_enable,
                    mode_type'(rsp_mon.motion_state)};
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with nothing expected: %s", $realtime,
                           $sformatf("status=%0d coils=%h en=%0d mode=%0d",
                                     got.status, got.coils, got.enable, got.mode));
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status || got.coils !== want.coils ||
                   got.enable !== want.enable || got.mode !== want.mode) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: expected status=%0d coils=%h en=%0d mode=%0d, %s",
                              $realtime, want.status, want.coils, want.enable, want.mode,
                              $sformatf("got status=%0d coils=%h en=%0d mode=%0d",
                                        got.status, got.coils, got.enable, got.mode));
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(advance_motion(cmd_type'(req_mon.cmd), req_mon.distance,
                                                     req_mon.speed));
      end
      results_due <= pending_results.size();
   end

endmodule

// ===== sim/stepper_phase_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for stepper_phase_sequencer_top: clock, reset, command and register stimulus,
// result back-pressure and the verdict. Depends on spsq_pkg, the interfaces and spsq_motion_checker.
module stepper_phase_sequencer_top_tb;
   import spsq_pkg::*;

   localparam int CycleLimit = 300000;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic                csr_index;
   logic [CfgWidth-1:0] csr_wdata;
   int                  fail_count;
   int                  results_due;
   int                  cycle_count = 0;

   int                  cur_rev;
   int                  cur_spr;
   bit                  idling = 1'b1;
   int                  gap_pct = 0;
   bit                  dirty = 1'b0;
   int                  items_sent = 0;
   int                  cmd_seen [4] = '{0, 0, 0, 0};
   int                  settings = 1;
   int                  phase_end;

   spsq_req_if req_chan ();
   spsq_rsp_if rsp_chan ();

   stepper_phase_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   spsq_motion_checker motion_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL stepper_phase_sequencer_top");
      $finish;
   end

   // Result side: bursts of stall, none once idling is off.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         if (idling && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   task automatic send_cmd(cmd_type cmd, logic [DistWidth-1:0] travel,
                           logic [SpeedWidth-1:0] spd);
      if (idling && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= cmd;
      req_chan.distance <= travel;
      req_chan.speed    <= spd;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      cmd_seen[cmd]++;
   endtask

   // Hold the sender until every result is back.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic set_config(int rev, int spr);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_REV_LENGTH;
      csr_wdata <= CfgWidth'(rev);
      @(posedge clock);
      csr_index <= CSR_STEPS_PER_REV;
      csr_wdata <= CfgWidth'(spr);
      @(posedge clock);
      csr_we  <= 1'b0;
      cur_rev = rev;
      cur_spr = spr;
      settings++;
   endtask

   // One move and, unless it is slow, enough ticks to finish it, with the odd stray command mixed in.
   task automatic run_motion();
      int          kmax;
      int          ticks;
      int unsigned travel;
      int unsigned goal;
      logic [SpeedWidth-1:0] spd;
      cmd_type     dir;
      bit          slow;
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 8 : 30);
      if (dirty || $urandom_range(0, 3) == 0)
         send_cmd(CMD_INIT, DistWidth'($urandom), SpeedWidth'($urandom));
      dirty = 1'b0;
      dir   = ($urandom_range(0, 1) == 0) ? CMD_FWD : CMD_BWD;
      kmax  = 12 / cur_spr;
      travel = $urandom_range(0, kmax) * cur_rev;
      if (cur_rev > 1) travel += $urandom_range(0, cur_rev - 1);
      if (travel > 65535) travel = 65535;
      goal  = (travel / cur_rev) * cur_spr;
      slow  = ($urandom_range(0, 9) == 0);
      spd   = slow ? SpeedWidth'($urandom) : SpeedWidth'($urandom_range(0, 3));
      send_cmd(dir, DistWidth'(travel), spd);
      // allow for a delay left over from the previous move
      ticks = slow ? $urandom_range(1, 4)
                   : (goal + 1) * ((spd == 0) ? 1 : spd) + 3 + $urandom_range(0, 6);
      repeat (ticks) begin
         if ($urandom_range(0, 24) == 0) begin
            send_cmd(cmd_type'($urandom_range(0, 3)), DistWidth'($urandom), SpeedWidth'($urandom));
            dirty = 1'b1;
         end else begin
            send_cmd(CMD_TICK, DistWidth'($urandom), SpeedWidth'($urandom));
         end
      end
      if (slow) send_cmd(CMD_INIT, DistWidth'($urandom), SpeedWidth'($urandom));
   endtask

   initial begin
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.cmd      <= CMD_TICK;
      req_chan.distance <= '0;
      req_chan.speed    <= '0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_REV_LENGTH;
      csr_wdata         <= '0;
      cur_rev = 1;
      cur_spr = 8;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: default registers, target zero at reset
      gap_pct = 20;
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);     // init with count at target
      send_cmd(CMD_TICK, 16'hFFFF, 16'hFFFF);     // tick in a done state
      send_cmd(CMD_FWD, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_FWD, 16'h0000, 16'h0000);      // refused, same direction runs
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);     // waiting on the long delay
      send_cmd(CMD_BWD, 16'h0000, 16'h0000);      // accepted, delay kept
      send_cmd(CMD_TICK, 16'hFFFF, 16'h0000);
      send_cmd(CMD_INIT, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_BWD, 16'h0001, 16'h0001);
      send_cmd(CMD_INIT, 16'h0000, 16'h0000);     // target stays
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);     // init with count off target
      set_config(0, 1);                           // zero divisor saturates
      send_cmd(CMD_FWD, 16'h0005, 16'h0000);
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);
      send_cmd(CMD_INIT, 16'h0000, 16'h0000);
      set_config(3, 1);
      send_cmd(CMD_FWD, 16'h0003, 16'h0000);
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);     // reaches forward done
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);
      send_cmd(CMD_FWD, 16'h0002, 16'h0000);      // accepted from forward done
      send_cmd(CMD_TICK, 16'h0000, 16'h0000);

      // random: one register setting per stretch, last stretch without idling
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: set_config(1, 1);
            1: set_config(65535, 65535);
            2: set_config($urandom_range(2, 400), $urandom_range(1, 6));
            3: set_config($urandom_range(1, 65535), $urandom_range(1, 12));
            default: begin
               set_config(7, 3);
               idling = 1'b0;
            end
         endcase
         phase_end = items_sent + 120;
         while (items_sent < phase_end) run_motion();
      end

      drain();
      repeat (25) @(posedge clock);
      $display("Ran %0d commands (%0d ticks, %0d forward, %0d backward, %0d init)",
               items_sent, cmd_seen[CMD_TICK], cmd_seen[CMD_FWD], cmd_seen[CMD_BWD],
               cmd_seen[CMD_INIT]);
      $display("over %0d register settings in %0d cycles, %0d failures",
               settings, cycle_count, fail_count);
      if (fail_count == 0 && results_due == 0) begin
         $display("PASS stepper_phase_sequencer_top");
      end else begin
         $display("FAIL stepper_phase_sequencer_top");
      end
      $finish;
   end

endmodule
